// ===== rtl/core/prt_pkg.sv =====
// Shared types, constants and helper functions of the point rotate and translate unit.
`default_nettype none

package prt_pkg;

   // Coordinates and rotation coefficients.
   localparam int CoordW       = 32;
   localparam int CoefFracBits = 14;
   localparam int CoefW        = CoefFracBits + 2;
   localparam int ProdW        = CoordW + CoefW;
   localparam int AccW         = ProdW + 1;

   // Angle handling: 1/128 degree units, a full turn is 46080 units.
   localparam int AngleW      = 17;
   localparam int AngleExtW   = AngleW + 1;
   localparam int FullTurn    = 46080;
   localparam int QuarterTurn = FullTurn / 4;
   localparam int TurnW       = 16;
   localparam int QuarterW    = 14;
   // A full turn is 2^10 * 45, so r * 2^32 / FullTurn is r * 2^22 / 45.
   localparam int TurnOdd     = FullTurn / 1024;
   localparam int ZFracW      = 22;
   // floor(r / 45) for r below 2^14 as (r * 23302) >> 20.
   localparam int RecipMul    = 23302;
   localparam int RecipSh     = 20;
   localparam int RecipProdW  = QuarterW + 15;
   localparam int CoarseW     = 8;
   localparam int FineW       = 6;
   localparam int ZTabDepth   = 64;

   // CORDIC datapath in Q4.30.
   localparam int CordicSteps = 16;
   localparam int AtanDepth   = 32;
   localparam int StepIdxW    = 5;
   localparam int CordicW     = 34;
   localparam int CordicZW    = 33;
   localparam int RoundSh     = 30 - CoefFracBits;
   localparam logic signed [CordicW-1:0] CordicGain = CordicW'(652032874);

   localparam logic [31:0] AtanTab [AtanDepth] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
      32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
      32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
   };

   typedef logic [ZFracW-1:0] zfrac_tab_type [ZTabDepth];

   function automatic zfrac_tab_type build_zfrac();
      zfrac_tab_type tab;
      for (int i = 0; i < ZTabDepth; i++) begin
         if (i < TurnOdd) begin
            tab[i] = ZFracW'((longint'(i) << ZFracW) / TurnOdd);
         end else begin
            tab[i] = '0;
         end
      end
      return tab;
   endfunction

   localparam zfrac_tab_type ZFracTab = build_zfrac();

   // Configuration register indexes.
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;
   localparam logic [CsrIdxW-1:0] RegAngleX = 3'd0;
   localparam logic [CsrIdxW-1:0] RegAngleY = 3'd1;
   localparam logic [CsrIdxW-1:0] RegAngleZ = 3'd2;
   localparam logic [CsrIdxW-1:0] RegShiftX = 3'd3;
   localparam logic [CsrIdxW-1:0] RegShiftY = 3'd4;
   localparam logic [CsrIdxW-1:0] RegShiftZ = 3'd5;

   // Rotation axes.
   localparam logic [1:0] AxisX = 2'd0;
   localparam logic [1:0] AxisY = 2'd1;
   localparam logic [1:0] AxisZ = 2'd2;

   localparam logic signed [CoefW-1:0] CoefOne  = CoefW'(2 ** CoefFracBits);
   localparam logic signed [CoefW-1:0] CoefZero = '0;

   localparam logic signed [AccW-1:0] CoordMaxW = AccW'((64'sd1 <<< (CoordW - 1)) - 64'sd1);
   localparam logic signed [AccW-1:0] CoordMinW = -CoordMaxW - AccW'(1);

   typedef struct packed {
      logic signed [CoefW-1:0] cos_v;
      logic signed [CoefW-1:0] sin_v;
   } coef_pair_type;

   // One vector travelling down the rotation chain: a and b are the pair being
   // rotated by this cell, p passes by untouched.
   typedef struct packed {
      logic                     is_normal;
      logic                     last;
      logic signed [CoordW-1:0] a;
      logic signed [CoordW-1:0] b;
      logic signed [CoordW-1:0] p;
   } rot_item_type;

   typedef struct packed {
      logic [1:0]                 axis;
      logic [1:0]                 quad;
      logic signed [CordicW-1:0]  x;
      logic signed [CordicW-1:0]  y;
      logic signed [CordicZW-1:0] z;
   } cordic_item_type;

   typedef struct packed {
      logic          valid;
      logic [1:0]    axis;
      coef_pair_type coef;
   } coef_wr_type;

   function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [AccW-1:0] v);
      if (v > CoordMaxW) begin
         return CoordMaxW[CoordW-1:0];
      end else if (v < CoordMinW) begin
         return CoordMinW[CoordW-1:0];
      end else begin
         return v[CoordW-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/point_rotate_translate_unit.sv =====
// Top level of the point rotate and translate unit.
//
// Usage: a vector transaction is taken when start is high and busy is low. Each
// vector is rotated about X, then Y, then Z, and points (not normals) get the
// shift registers added; coordinates are signed Q16.16 and saturate.
// The rotation runs through a chain of three identical rotation cells of two
// stages each, plus an output register, so a result shows on the rsp_ ports
// with rsp_valid high for one cycle. One vector can be started every cycle
// while busy is low; the receiver cannot stall the results.
// Configuration is written over the csr_ channel (valid/ready, index, data).
// An angle write starts the sine/cosine unit: range reduction (turn, quadrant,
// division by 45, binary angle), a chain of 16 CORDIC cells and a rounding stage.
// While it runs, csr_ready and busy are held low/high respectively, and the
// new coefficients apply to every vector started after busy falls.
// Shift writes take effect at once. Writes to unknown indexes are ignored.
// Reset clears the pipeline, sets all angles and shifts to zero (cosines to
// one, sines to zero), and the block is ready on the first cycle after reset.
`default_nettype none

module point_rotate_translate_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [prt_pkg::CoordW-1:0]  req_vec_x,
   input  logic signed [prt_pkg::CoordW-1:0]  req_vec_y,
   input  logic signed [prt_pkg::CoordW-1:0]  req_vec_z,
   input  logic                               req_is_normal,
   input  logic                               req_last_item,
   output logic                               rsp_valid,
   output logic signed [prt_pkg::CoordW-1:0]  rsp_res_x,
   output logic signed [prt_pkg::CoordW-1:0]  rsp_res_y,
   output logic signed [prt_pkg::CoordW-1:0]  rsp_res_z,
   output logic                               rsp_res_is_normal,
   output logic                               rsp_res_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [prt_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [prt_pkg::CsrDataW-1:0]       csr_wdata
);
   import prt_pkg::*;

   logic          csr_wr;
   logic          trig_wr;
   logic [1:0]    trig_axis;
   coef_wr_type   coef_wr;
   logic          trig_busy_in;
   logic          trig_busy_ff;

   coef_pair_type coef_x_in;
   coef_pair_type coef_y_in;
   coef_pair_type coef_z_in;
   coef_pair_type coef_x_ff;
   coef_pair_type coef_y_ff;
   coef_pair_type coef_z_ff;
   logic signed [CoordW-1:0] shift_x_in;
   logic signed [CoordW-1:0] shift_y_in;
   logic signed [CoordW-1:0] shift_z_in;
   logic signed [CoordW-1:0] shift_x_ff;
   logic signed [CoordW-1:0] shift_y_ff;
   logic signed [CoordW-1:0] shift_z_ff;

   logic          req_accept;
   rot_item_type  x_cell_in;
   rot_item_type  x_cell_out;
   rot_item_type  y_cell_in;
   rot_item_type  y_cell_out;
   rot_item_type  z_cell_in;
   rot_item_type  z_cell_out;
   logic          x_cell_valid;
   logic          y_cell_valid;
   logic          z_cell_valid;

   logic signed [CoordW-1:0] res_x_in;
   logic signed [CoordW-1:0] res_y_in;
   logic signed [CoordW-1:0] res_z_in;
   logic signed [CoordW-1:0] res_x_ff;
   logic signed [CoordW-1:0] res_y_ff;
   logic signed [CoordW-1:0] res_z_ff;
   logic                     res_is_normal_ff;
   logic                     res_last_ff;
   logic                     rsp_valid_ff;

   // Configuration writes.
   assign csr_ready = !trig_busy_ff;
   assign csr_wr    = csr_valid && csr_ready;
   assign busy      = trig_busy_ff;

   always_comb begin
      trig_wr   = 1'b0;
      trig_axis = AxisX;
      case (csr_index)
         RegAngleX: begin
            trig_wr   = csr_wr;
            trig_axis = AxisX;
         end
         RegAngleY: begin
            trig_wr   = csr_wr;
            trig_axis = AxisY;
         end
         RegAngleZ: begin
            trig_wr   = csr_wr;
            trig_axis = AxisZ;
         end
         default: begin
            trig_wr   = 1'b0;
            trig_axis = AxisX;
         end
      endcase
   end

   prt_trig u_trig (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (trig_wr),
      .wr_axis  (trig_axis),
      .wr_angle (csr_wdata[AngleW-1:0]),
      .coef_wr  (coef_wr)
   );

   always_comb begin
      trig_busy_in = trig_busy_ff;
      if (trig_wr) begin
         trig_busy_in = 1'b1;
      end else if (coef_wr.valid) begin
         trig_busy_in = 1'b0;
      end
   end

   always_comb begin
      coef_x_in  = coef_x_ff;
      coef_y_in  = coef_y_ff;
      coef_z_in  = coef_z_ff;
      shift_x_in = shift_x_ff;
      shift_y_in = shift_y_ff;
      shift_z_in = shift_z_ff;
      if (coef_wr.valid) begin
         case (coef_wr.axis)
            AxisX:   coef_x_in = coef_wr.coef;
            AxisY:   coef_y_in = coef_wr.coef;
            AxisZ:   coef_z_in = coef_wr.coef;
            default: coef_x_in = coef_x_ff;
         endcase
      end
      if (csr_wr) begin
         case (csr_index)
            RegShiftX: shift_x_in = csr_wdata[CoordW-1:0];
            RegShiftY: shift_y_in = csr_wdata[CoordW-1:0];
            RegShiftZ: shift_z_in = csr_wdata[CoordW-1:0];
            default:   shift_x_in = shift_x_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_busy_ff    <= 1'b0;
         coef_x_ff.cos_v <= CoefOne;
         coef_x_ff.sin_v <= CoefZero;
         coef_y_ff.cos_v <= CoefOne;
         coef_y_ff.sin_v <= CoefZero;
         coef_z_ff.cos_v <= CoefOne;
         coef_z_ff.sin_v <= CoefZero;
         shift_x_ff      <= '0;
         shift_y_ff      <= '0;
         shift_z_ff      <= '0;
      end else begin
         trig_busy_ff    <= trig_busy_in;
         coef_x_ff       <= coef_x_in;
         coef_y_ff       <= coef_y_in;
         coef_z_ff       <= coef_z_in;
         shift_x_ff      <= shift_x_in;
         shift_y_ff      <= shift_y_in;
         shift_z_ff      <= shift_z_in;
      end
   end

   // Rotation chain. Each cell rotates its (a, b) pair; the wiring between
   // cells picks which two coordinates form that pair.
   assign req_accept = start && !busy;

   always_comb begin
      x_cell_in.is_normal = req_is_normal;
      x_cell_in.last      = req_last_item;
      x_cell_in.a         = req_vec_y;
      x_cell_in.b         = req_vec_z;
      x_cell_in.p         = req_vec_x;

      // About Y: z' = z*cy - x*sy and x' = z*sy + x*cy.
      y_cell_in.is_normal = x_cell_out.is_normal;
      y_cell_in.last      = x_cell_out.last;
      y_cell_in.a         = x_cell_out.b;
      y_cell_in.b         = x_cell_out.p;
      y_cell_in.p         = x_cell_out.a;

      z_cell_in.is_normal = y_cell_out.is_normal;
      z_cell_in.last      = y_cell_out.last;
      z_cell_in.a         = y_cell_out.b;
      z_cell_in.b         = y_cell_out.p;
      z_cell_in.p         = y_cell_out.a;
   end

   prt_rot_cell u_rot_x (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_x_ff),
      .in_valid  (req_accept),
      .in_item   (x_cell_in),
      .out_valid (x_cell_valid),
      .out_item  (x_cell_out)
   );

   prt_rot_cell u_rot_y (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_y_ff),
      .in_valid  (x_cell_valid),
      .in_item   (y_cell_in),
      .out_valid (y_cell_valid),
      .out_item  (y_cell_out)
   );

   prt_rot_cell u_rot_z (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_z_ff),
      .in_valid  (y_cell_valid),
      .in_item   (z_cell_in),
      .out_valid (z_cell_valid),
      .out_item  (z_cell_out)
   );

   // Translation of points and the output register.
   always_comb begin
      if (z_cell_out.is_normal) begin
         res_x_in = z_cell_out.a;
         res_y_in = z_cell_out.b;
         res_z_in = z_cell_out.p;
      end else begin
         res_x_in = sat_coord(AccW'(z_cell_out.a) + AccW'(shift_x_ff));
         res_y_in = sat_coord(AccW'(z_cell_out.b) + AccW'(shift_y_ff));
         res_z_in = sat_coord(AccW'(z_cell_out.p) + AccW'(shift_z_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= z_cell_valid;
      end
   end

   always_ff @(posedge clock) begin
      res_x_ff         <= res_x_in;
      res_y_ff         <= res_y_in;
      res_z_ff         <= res_z_in;
      res_is_normal_ff <= z_cell_out.is_normal;
      res_last_ff      <= z_cell_out.last;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_res_x         = res_x_ff;
   assign rsp_res_y         = res_y_ff;
   assign rsp_res_z         = res_z_ff;
   assign rsp_res_is_normal = res_is_normal_ff;
   assign rsp_res_last      = res_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/prt_cordic_cell.sv =====
// One CORDIC rotation step with its output register.
`default_nettype none

module prt_cordic_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [prt_pkg::StepIdxW-1:0] step_idx,
   input  logic                     in_valid,
   input  prt_pkg::cordic_item_type in_item,
   output logic                     out_valid,
   output prt_pkg::cordic_item_type out_item
);
   import prt_pkg::*;

   logic signed [CordicW-1:0]  x_cur;
   logic signed [CordicW-1:0]  y_cur;
   logic signed [CordicZW-1:0] z_cur;
   logic signed [CordicW-1:0]  dx;
   logic signed [CordicW-1:0]  dy;
   logic signed [CordicZW-1:0] step_ang;
   cordic_item_type            item_in;
   cordic_item_type            item_ff;
   logic                       valid_ff;

   always_comb begin
      x_cur    = in_item.x;
      y_cur    = in_item.y;
      z_cur    = in_item.z;
      dx       = y_cur >>> step_idx;
      dy       = x_cur >>> step_idx;
      step_ang = CordicZW'(AtanTab[step_idx]);
      item_in  = in_item;
      // Rotate toward the residual angle: positive residual turns counterclockwise.
      if (!z_cur[CordicZW-1]) begin
         item_in.x = x_cur - dx;
         item_in.y = y_cur + dy;
         item_in.z = z_cur - step_ang;
      end else begin
         item_in.x = x_cur + dx;
         item_in.y = y_cur - dy;
         item_in.z = z_cur + step_ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ===== rtl/core/prt_trig.sv =====
// Sine and cosine of a written angle: range reduction, CORDIC chain and rounding.
`default_nettype none

module prt_trig (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_valid,
   input  logic [1:0]                    wr_axis,
   input  logic signed [prt_pkg::AngleW-1:0] wr_angle,
   output prt_pkg::coef_wr_type          coef_wr
);
   import prt_pkg::*;

   localparam logic [1:0] Quad0 = 2'd0;
   localparam logic [1:0] Quad1 = 2'd1;
   localparam logic [1:0] Quad2 = 2'd2;
   localparam logic [1:0] Quad3 = 2'd3;

   localparam logic signed [AngleExtW-1:0] FullTurnS = AngleExtW'(FullTurn);
   localparam logic signed [CordicW-1:0]   HalfLsb   = CordicW'(2 ** (RoundSh - 1));
   localparam logic signed [CordicW-1:0]   OneW      = CordicW'(2 ** CoefFracBits);

   // Stage 0: reduce the angle into one turn.
   logic signed [AngleExtW-1:0] ang_ext;
   logic signed [AngleExtW-1:0] ang_p1;
   logic signed [AngleExtW-1:0] ang_p2;
   logic [TurnW-1:0]            turn_in;
   logic [TurnW-1:0]            turn_ff;
   logic                        s0_valid_ff;
   logic [1:0]                  s0_axis_ff;

   // Stage 1: quadrant and remainder.
   logic [1:0]          quad_in;
   logic [QuarterW-1:0] rem_in;
   logic [1:0]          s1_quad_ff;
   logic [QuarterW-1:0] s1_rem_ff;
   logic                s1_valid_ff;
   logic [1:0]          s1_axis_ff;

   // Stage 2: remainder divided by 45 through a reciprocal.
   logic [RecipProdW-1:0] recip_prod;
   logic [CoarseW-1:0]    coarse_in;
   logic [CoarseW-1:0]    s2_coarse_ff;
   logic [QuarterW-1:0]   s2_rem_ff;
   logic [1:0]            s2_quad_ff;
   logic                  s2_valid_ff;
   logic [1:0]            s2_axis_ff;

   // Stage 3: binary angle, fed into the CORDIC chain.
   logic [QuarterW-1:0] fine_full;
   logic [FineW-1:0]    fine_idx;
   cordic_item_type     chain_item [CordicSteps+1];
   logic                chain_valid [CordicSteps+1];
   cordic_item_type     start_item_in;
   cordic_item_type     start_item_ff;
   logic                start_valid_ff;

   // Output stage.
   logic signed [CordicW-1:0] x_rnd;
   logic signed [CordicW-1:0] y_rnd;
   logic signed [CoefW-1:0]   cv;
   logic signed [CoefW-1:0]   sv;
   coef_wr_type               coef_in;
   coef_wr_type               coef_ff;

   function automatic logic signed [CoefW-1:0] clamp_coef(input logic signed [CordicW-1:0] v);
      if (v > OneW) begin
         return CoefW'(OneW);
      end else if (v < -OneW) begin
         return CoefW'(-OneW);
      end else begin
         return CoefW'(v);
      end
   endfunction

   always_comb begin
      ang_ext = AngleExtW'(wr_angle);
      ang_p1  = ang_ext[AngleExtW-1] ? ang_ext + FullTurnS : ang_ext;
      ang_p2  = ang_p1[AngleExtW-1] ? ang_p1 + FullTurnS : ang_p1;
      if (ang_p2 >= FullTurnS) begin
         turn_in = TurnW'(ang_p2 - FullTurnS);
      end else begin
         turn_in = TurnW'(ang_p2);
      end
   end

   always_comb begin
      if (turn_ff >= TurnW'(3 * QuarterTurn)) begin
         quad_in = Quad3;
         rem_in  = QuarterW'(turn_ff - TurnW'(3 * QuarterTurn));
      end else if (turn_ff >= TurnW'(2 * QuarterTurn)) begin
         quad_in = Quad2;
         rem_in  = QuarterW'(turn_ff - TurnW'(2 * QuarterTurn));
      end else if (turn_ff >= TurnW'(QuarterTurn)) begin
         quad_in = Quad1;
         rem_in  = QuarterW'(turn_ff - TurnW'(QuarterTurn));
      end else begin
         quad_in = Quad0;
         rem_in  = QuarterW'(turn_ff);
      end
   end

   always_comb begin
      recip_prod = RecipProdW'(s1_rem_ff) * RecipProdW'(RecipMul);
      coarse_in  = recip_prod[RecipSh +: CoarseW];
   end

   always_comb begin
      fine_full            = s2_rem_ff - QuarterW'(s2_coarse_ff) * QuarterW'(TurnOdd);
      fine_idx             = fine_full[FineW-1:0];
      start_item_in.axis   = s2_axis_ff;
      start_item_in.quad   = s2_quad_ff;
      start_item_in.x      = CordicGain;
      start_item_in.y      = '0;
      start_item_in.z      = CordicZW'({s2_coarse_ff, ZFracTab[fine_idx]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         start_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff    <= wr_valid;
         s1_valid_ff    <= s0_valid_ff;
         s2_valid_ff    <= s1_valid_ff;
         start_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_axis_ff    <= wr_axis;
      turn_ff       <= turn_in;
      s1_axis_ff    <= s0_axis_ff;
      s1_quad_ff    <= quad_in;
      s1_rem_ff     <= rem_in;
      s2_axis_ff    <= s1_axis_ff;
      s2_quad_ff    <= s1_quad_ff;
      s2_rem_ff     <= s1_rem_ff;
      s2_coarse_ff  <= coarse_in;
      start_item_ff <= start_item_in;
   end

   assign chain_item[0]  = start_item_ff;
   assign chain_valid[0] = start_valid_ff;

   for (genvar g = 0; g < CordicSteps; g++) begin : g_step
      prt_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (StepIdxW'(g)),
         .in_valid  (chain_valid[g]),
         .in_item   (chain_item[g]),
         .out_valid (chain_valid[g+1]),
         .out_item  (chain_item[g+1])
      );
   end

   always_comb begin
      x_rnd = (chain_item[CordicSteps].x + HalfLsb) >>> RoundSh;
      y_rnd = (chain_item[CordicSteps].y + HalfLsb) >>> RoundSh;
      cv    = clamp_coef(x_rnd);
      sv    = clamp_coef(y_rnd);
      coef_in.valid = chain_valid[CordicSteps];
      coef_in.axis  = chain_item[CordicSteps].axis;
      case (chain_item[CordicSteps].quad)
         Quad0: begin
            coef_in.coef.cos_v = cv;
            coef_in.coef.sin_v = sv;
         end
         Quad1: begin
            coef_in.coef.cos_v = -sv;
            coef_in.coef.sin_v = cv;
         end
         Quad2: begin
            coef_in.coef.cos_v = -cv;
            coef_in.coef.sin_v = -sv;
         end
         default: begin
            coef_in.coef.cos_v = sv;
            coef_in.coef.sin_v = -cv;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.valid <= 1'b0;
         coef_ff.axis  <= AxisX;
         coef_ff.coef  <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef_wr = coef_ff;

endmodule

`default_nettype wire

// ===== rtl/core/prt_rot_cell.sv =====
// One plane rotation of the vector chain: products, then rounded and saturated sums.
`default_nettype none

module prt_rot_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  prt_pkg::coef_pair_type coef,
   input  logic                   in_valid,
   input  prt_pkg::rot_item_type  in_item,
   output logic                   out_valid,
   output prt_pkg::rot_item_type  out_item
);
   import prt_pkg::*;

   localparam logic signed [AccW-1:0] RoundAcc = AccW'(2 ** (CoefFracBits - 1));

   logic signed [CoordW-1:0] a_cur;
   logic signed [CoordW-1:0] b_cur;
   logic signed [ProdW-1:0]  ac_in;
   logic signed [ProdW-1:0]  bs_in;
   logic signed [ProdW-1:0]  as_in;
   logic signed [ProdW-1:0]  bc_in;
   logic signed [ProdW-1:0]  ac_ff;
   logic signed [ProdW-1:0]  bs_ff;
   logic signed [ProdW-1:0]  as_ff;
   logic signed [ProdW-1:0]  bc_ff;
   logic signed [CoordW-1:0] p_ff;
   logic                     is_normal_ff;
   logic                     last_ff;
   logic                     mul_valid_ff;

   logic signed [AccW-1:0]   sum_a;
   logic signed [AccW-1:0]   sum_b;
   rot_item_type             item_in;
   rot_item_type             item_ff;
   logic                     valid_ff;

   always_comb begin
      a_cur = in_item.a;
      b_cur = in_item.b;
      ac_in = ProdW'(a_cur) * ProdW'(coef.cos_v);
      bs_in = ProdW'(b_cur) * ProdW'(coef.sin_v);
      as_in = ProdW'(a_cur) * ProdW'(coef.sin_v);
      bc_in = ProdW'(b_cur) * ProdW'(coef.cos_v);
   end

   always_comb begin
      sum_a = AccW'(ac_ff) - AccW'(bs_ff) + RoundAcc;
      sum_b = AccW'(as_ff) + AccW'(bc_ff) + RoundAcc;
      item_in.is_normal = is_normal_ff;
      item_in.last      = last_ff;
      item_in.a         = sat_coord(sum_a >>> CoefFracBits);
      item_in.b         = sat_coord(sum_b >>> CoefFracBits);
      item_in.p         = p_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         mul_valid_ff <= in_valid;
         valid_ff     <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      ac_ff        <= ac_in;
      bs_ff        <= bs_in;
      as_ff        <= as_in;
      bc_ff        <= bc_in;
      p_ff         <= in_item.p;
      is_normal_ff <= in_item.is_normal;
      last_ff      <= in_item.last;
      item_ff      <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ===== tb/point_rotate_translate_unit_tb.sv =====
// Self-checking testbench for the point rotate and translate unit.
module point_rotate_translate_unit_tb;

   localparam int W = prt_pkg::CoordW;
   localparam int IdxW = prt_pkg::CsrIdxW;
   localparam int DataW = prt_pkg::CsrDataW;
   localparam int StallLimit = 2000;
   localparam int DrainCycles = 16;
   localparam int RandomPerPhase = 283;
   localparam int RetuneEvery = 47;
   localparam int MaxPrinted = 100;

   localparam logic signed [W-1:0] CoordMax = 32'sh7FFF_FFFF;
   localparam logic signed [W-1:0] CoordMin = 32'sh8000_0000;

   // Indexes that decode to no register; writes there must be dropped.
   localparam logic [IdxW-1:0] RegSpare6 = 3'd6;
   localparam logic [IdxW-1:0] RegSpare7 = 3'd7;

   // Angles in 1/128 degree units.
   localparam int AngleEighth = 5760;
   localparam int AngleQuarter = 11520;
   localparam int AngleHalf = 23040;
   localparam int AngleFull = 46080;
   localparam int AngleFieldMax = 65535;
   localparam int AngleFieldMin = -65536;

   localparam longint CoefUnit = longint'(1) << prt_pkg::CoefFracBits;
   localparam longint CordicGainQ30 = 652032874;
   localparam int CordicIters = 16;
   localparam longint AtanSteps [CordicIters] = '{
      64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
      64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
      64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
      64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D
   };

   typedef enum logic {RowVector, RowWrite} row_kind_type;

   typedef struct packed {
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic signed [W-1:0] z;
      logic                is_normal;
      logic                last;
   } vec_fields_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [IdxW-1:0]  index;
      logic [DataW-1:0] data;
      vec_fields_type   stim;
      logic             typed;
      vec_fields_type   want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic signed [W-1:0] req_vec_x;
   logic signed [W-1:0] req_vec_y;
   logic signed [W-1:0] req_vec_z;
   logic req_is_normal;
   logic req_last_item;
   logic rsp_valid;
   logic signed [W-1:0] rsp_res_x;
   logic signed [W-1:0] rsp_res_y;
   logic signed [W-1:0] rsp_res_z;
   logic rsp_res_is_normal;
   logic rsp_res_last;
   logic csr_valid;
   logic csr_ready;
   logic [IdxW-1:0] csr_index;
   logic [DataW-1:0] csr_wdata;

   point_rotate_translate_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_vec_x         (req_vec_x),
      .req_vec_y         (req_vec_y),
      .req_vec_z         (req_vec_z),
      .req_is_normal     (req_is_normal),
      .req_last_item     (req_last_item),
      .rsp_valid         (rsp_valid),
      .rsp_res_x         (rsp_res_x),
      .rsp_res_y         (rsp_res_y),
      .rsp_res_z         (rsp_res_z),
      .rsp_res_is_normal (rsp_res_is_normal),
      .rsp_res_last      (rsp_res_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Predicted rotation coefficients and shifts, indexed by axis.
   longint coef_cos [3] = '{CoefUnit, CoefUnit, CoefUnit};
   longint coef_sin [3] = '{0, 0, 0};
   longint shift_v [3] = '{0, 0, 0};

   vec_fields_type pending_results [$];
   stim_row_type dir_rows [$];

   int idle_pct = 9;
   int vectors_sent = 0;
   int register_writes = 0;
   int results_checked = 0;
   int mismatches = 0;
   int stall_cycles = 0;
   bit start_held = 1'b0;
   bit csr_held = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint clamp_coord(input longint v);
      longint hi;
      hi = (longint'(1) << (W - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // One output of a rotation stage: round half up, then saturate.
   function automatic longint rot_term(input longint a1, c1, a2, c2);
      longint acc;
      acc = a1 * c1 + a2 * c2 + (longint'(1) << (prt_pkg::CoefFracBits - 1));
      return clamp_coord(acc >>> prt_pkg::CoefFracBits);
   endfunction

   function automatic void sincos_of(input logic signed [16:0] angle,
                                     output longint c, output longint s);
      longint a, quad, rem, cx, cy, cz, dx, dy, cv, sv;
      a = longint'(angle) % AngleFull;
      if (a < 0) a += AngleFull;
      quad = a / AngleQuarter;
      rem = a % AngleQuarter;
      // Remainder as a binary angle where 2^32 is a full turn.
      cz = (rem << 32) / AngleFull;
      cx = CordicGainQ30;
      cy = 0;
      for (int i = 0; i < CordicIters; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cz >= 0) begin
            cx -= dx;
            cy += dy;
            cz -= AtanSteps[i];
         end else begin
            cx += dx;
            cy -= dy;
            cz += AtanSteps[i];
         end
      end
      cv = (cx + (longint'(1) << 15)) >>> 16;
      sv = (cy + (longint'(1) << 15)) >>> 16;
      if (cv > CoefUnit) cv = CoefUnit;
      if (cv < -CoefUnit) cv = -CoefUnit;
      if (sv > CoefUnit) sv = CoefUnit;
      if (sv < -CoefUnit) sv = -CoefUnit;
      case (quad)
         0: begin
            c = cv;
            s = sv;
         end
         1: begin
            c = -sv;
            s = cv;
         end
         2: begin
            c = -cv;
            s = -sv;
         end
         default: begin
            c = sv;
            s = -cv;
         end
      endcase
   endfunction

   function automatic void apply_register(input logic [IdxW-1:0] index,
                                          input logic [DataW-1:0] data);
      case (index)
         prt_pkg::RegAngleX:
            sincos_of(data[16:0], coef_cos[prt_pkg::AxisX], coef_sin[prt_pkg::AxisX]);
         prt_pkg::RegAngleY:
            sincos_of(data[16:0], coef_cos[prt_pkg::AxisY], coef_sin[prt_pkg::AxisY]);
         prt_pkg::RegAngleZ:
            sincos_of(data[16:0], coef_cos[prt_pkg::AxisZ], coef_sin[prt_pkg::AxisZ]);
         prt_pkg::RegShiftX: shift_v[prt_pkg::AxisX] = longint'($signed(data));
         prt_pkg::RegShiftY: shift_v[prt_pkg::AxisY] = longint'($signed(data));
         prt_pkg::RegShiftZ: shift_v[prt_pkg::AxisZ] = longint'($signed(data));
         default: ;
      endcase
   endfunction

   function automatic vec_fields_type transform_vector(input vec_fields_type v);
      vec_fields_type r;
      longint px, py, pz, t1, t2, cx, sx, cy, sy, cz, sz;
      cx = coef_cos[prt_pkg::AxisX];
      sx = coef_sin[prt_pkg::AxisX];
      cy = coef_cos[prt_pkg::AxisY];
      sy = coef_sin[prt_pkg::AxisY];
      cz = coef_cos[prt_pkg::AxisZ];
      sz = coef_sin[prt_pkg::AxisZ];
      px = v.x;
      py = v.y;
      pz = v.z;
      t1 = rot_term(py, cx, pz, -sx);
      t2 = rot_term(py, sx, pz, cx);
      py = t1;
      pz = t2;
      t1 = rot_term(px, cy, pz, sy);
      t2 = rot_term(px, -sy, pz, cy);
      px = t1;
      pz = t2;
      t1 = rot_term(px, cz, py, -sz);
      t2 = rot_term(px, sz, py, cz);
      px = t1;
      py = t2;
      // Normals are direction vectors, so only points are translated.
      if (!v.is_normal) begin
         px = clamp_coord(px + shift_v[prt_pkg::AxisX]);
         py = clamp_coord(py + shift_v[prt_pkg::AxisY]);
         pz = clamp_coord(pz + shift_v[prt_pkg::AxisZ]);
      end
      r.x = px[W-1:0];
      r.y = py[W-1:0];
      r.z = pz[W-1:0];
      r.is_normal = v.is_normal;
      r.last = v.last;
      return r;
   endfunction

   function automatic stim_row_type fixed_row(input logic signed [W-1:0] x, y, z,
                                              input logic nrm, lst,
                                              input logic signed [W-1:0] ex, ey, ez);
      stim_row_type row;
      row = '0;
      row.kind = RowVector;
      row.stim = '{x, y, z, nrm, lst};
      row.typed = 1'b1;
      row.want = '{ex, ey, ez, nrm, lst};
      return row;
   endfunction

   function automatic stim_row_type pred_row(input logic signed [W-1:0] x, y, z,
                                             input logic nrm, lst);
      stim_row_type row;
      row = '0;
      row.kind = RowVector;
      row.stim = '{x, y, z, nrm, lst};
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [IdxW-1:0] index,
                                            input logic [DataW-1:0] data);
      stim_row_type row;
      row = '0;
      row.kind = RowWrite;
      row.index = index;
      row.data = data;
      return row;
   endfunction

   function automatic logic [W-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return CoordMax;
               1: return CoordMin;
               2: return '0;
               3: return '1;
               default: return 32'd1;
            endcase
         end
         1, 2, 3, 4: return $urandom();
         default: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
      endcase
   endfunction

   function automatic logic [DataW-1:0] rand_angle();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 7))
               0: return '0;
               1: return 32'(AngleFull);
               2: return 32'(-AngleFull);
               3: return 32'(AngleFieldMax);
               4: return 32'(AngleFieldMin);
               5: return 32'(AngleQuarter);
               6: return 32'(-AngleQuarter);
               default: return 32'(AngleHalf);
            endcase
         end
         1: return 32'(int'($urandom_range(0, 131071)) - 65536);
         default: return 32'(int'($urandom_range(0, 2 * AngleFull)) - AngleFull);
      endcase
   endfunction

   function automatic logic [DataW-1:0] rand_shift();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 2))
               0: return CoordMax;
               1: return CoordMin;
               default: return '0;
            endcase
         end
         1, 2: return $urandom();
         default: return 32'(int'($urandom_range(0, 8388608)) - 4194304);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatches < MaxPrinted) begin
         $display("mismatch at result %0d on %s: got %0d, expected %0d",
                  results_checked, what, got, want);
      end
      mismatches++;
   endtask

   // Stops sending and waits until every vector in flight has come back.
   task automatic drain();
      if (start_held) begin
         start <= 1'b0;
         start_held = 1'b0;
      end
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Leaves csr_valid high; the next write or vector in the same step takes it over.
   task automatic write_register(input logic [IdxW-1:0] index, input logic [DataW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      csr_held = 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_register(index, data);
      register_writes++;
   endtask

   task automatic send_vector(input vec_fields_type v, input logic typed,
                              input vec_fields_type want);
      if (csr_held) begin
         csr_valid <= 1'b0;
         csr_held = 1'b0;
      end
      while ($urandom_range(0, 99) < idle_pct) begin
         if (start_held) begin
            start <= 1'b0;
            start_held = 1'b0;
         end
         @(posedge clock);
      end
      start <= 1'b1;
      start_held = 1'b1;
      req_vec_x <= v.x;
      req_vec_y <= v.y;
      req_vec_z <= v.z;
      req_is_normal <= v.is_normal;
      req_last_item <= v.last;
      do @(posedge clock); while (busy !== 1'b0);
      pending_results.push_back(typed ? want : transform_vector(v));
      vectors_sent++;
   endtask

   always @(posedge clock) begin
      vec_fields_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_res_x !== want.x) report_mismatch("res_x", rsp_res_x, want.x);
            if (rsp_res_y !== want.y) report_mismatch("res_y", rsp_res_y, want.y);
            if (rsp_res_z !== want.z) report_mismatch("res_z", rsp_res_z, want.z);
            if (rsp_res_is_normal !== want.is_normal) begin
               report_mismatch("res_is_normal", rsp_res_is_normal, want.is_normal);
            end
            if (rsp_res_last !== want.last) report_mismatch("res_last", rsp_res_last, want.last);
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1 ||
          (csr_valid && csr_ready === 1'b1)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  stall_cycles, pending_results.size());
         $display("point_rotate_translate_unit_tb NOT OK");
         $finish;
      end
   end

   initial begin
      vec_fields_type v;
      int idle_profile [3];
      reset <= 1'b1;
      start <= 1'b0;
      req_vec_x <= '0;
      req_vec_y <= '0;
      req_vec_z <= '0;
      req_is_normal <= 1'b0;
      req_last_item <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      idle_profile = '{9, 72, 0};

      // With reset coefficients and zero shifts every vector passes unchanged.
      dir_rows.push_back(fixed_row(0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(fixed_row(CoordMax, CoordMax, CoordMax, 0, 1,
                                   CoordMax, CoordMax, CoordMax));
      dir_rows.push_back(fixed_row(CoordMin, CoordMin, CoordMin, 1, 0,
                                   CoordMin, CoordMin, CoordMin));
      dir_rows.push_back(fixed_row(1, -1, 32'sh0001_0000, 0, 1, 1, -1, 32'sh0001_0000));
      dir_rows.push_back(fixed_row(CoordMax, CoordMin, 32'sh5555_5555, 1, 1,
                                   CoordMax, CoordMin, 32'sh5555_5555));
      dir_rows.push_back(fixed_row(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 0, 0,
                                   32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA));
      // Extreme shifts saturate points and leave normals alone; spare index writes are dropped.
      dir_rows.push_back(csr_row(prt_pkg::RegShiftX, CoordMax));
      dir_rows.push_back(csr_row(prt_pkg::RegShiftY, CoordMin));
      dir_rows.push_back(csr_row(prt_pkg::RegShiftZ, 32'h0001_8000));
      dir_rows.push_back(fixed_row(CoordMax, CoordMin, 0, 0, 0,
                                   CoordMax, CoordMin, 32'sh0001_8000));
      dir_rows.push_back(fixed_row(CoordMax, CoordMin, 0, 1, 1, CoordMax, CoordMin, 0));
      dir_rows.push_back(fixed_row(0, 0, CoordMin, 0, 0, CoordMax, CoordMin, 32'sh8001_8000));
      dir_rows.push_back(csr_row(RegSpare6, 32'hFFFF_FFFF));
      dir_rows.push_back(csr_row(RegSpare7, 32'h0000_0000));
      dir_rows.push_back(pred_row(1, 2, 3, 0, 1));
      // Quadrant boundaries, then the field limits (past a full turn), then a full turn each way.
      dir_rows.push_back(csr_row(prt_pkg::RegAngleX, 32'(AngleQuarter)));
      dir_rows.push_back(csr_row(prt_pkg::RegAngleY, 32'(-AngleQuarter)));
      dir_rows.push_back(csr_row(prt_pkg::RegAngleZ, 32'(AngleHalf)));
      dir_rows.push_back(pred_row(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0));
      dir_rows.push_back(pred_row(CoordMax, CoordMin, CoordMax, 1, 1));
      dir_rows.push_back(csr_row(prt_pkg::RegAngleX, 32'(AngleFieldMax)));
      dir_rows.push_back(csr_row(prt_pkg::RegAngleY, 32'(AngleFieldMin)));
      dir_rows.push_back(csr_row(prt_pkg::RegAngleZ, 32'(AngleEighth)));
      dir_rows.push_back(pred_row(CoordMax, CoordMax, CoordMax, 0, 0));
      dir_rows.push_back(pred_row(CoordMin, CoordMax, -1, 1, 0));
      dir_rows.push_back(csr_row(prt_pkg::RegAngleX, 32'(AngleFull)));
      dir_rows.push_back(csr_row(prt_pkg::RegAngleY, 32'(-AngleFull)));
      dir_rows.push_back(csr_row(prt_pkg::RegShiftX, 32'h0000_0000));
      dir_rows.push_back(pred_row(CoordMax, CoordMax, CoordMin, 0, 1));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == RowWrite) begin
            drain();
            write_register(dir_rows[i].index, dir_rows[i].data);
         end else begin
            send_vector(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      for (int p = 0; p < 3; p++) begin
         idle_pct = idle_profile[p];
         for (int n = 0; n < RandomPerPhase; n++) begin
            // Retune only once the pipeline is empty.
            if (n % RetuneEvery == 0) begin
               drain();
               if ($urandom_range(0, 1)) write_register(prt_pkg::RegAngleX, rand_angle());
               if ($urandom_range(0, 1)) write_register(prt_pkg::RegAngleY, rand_angle());
               if ($urandom_range(0, 1)) write_register(prt_pkg::RegAngleZ, rand_angle());
               if ($urandom_range(0, 1)) write_register(prt_pkg::RegShiftX, rand_shift());
               if ($urandom_range(0, 1)) write_register(prt_pkg::RegShiftY, rand_shift());
               if ($urandom_range(0, 1)) write_register(prt_pkg::RegShiftZ, rand_shift());
               if ($urandom_range(0, 7) == 0) begin
                  write_register($urandom_range(0, 1) ? RegSpare6 : RegSpare7, $urandom());
               end
            end
            v.x = rand_coord();
            v.y = rand_coord();
            v.z = rand_coord();
            v.is_normal = 1'($urandom_range(0, 1));
            v.last = 1'($urandom_range(0, 1));
            send_vector(v, 1'b0, '0);
         end
      end

      drain();
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d vectors over directed rows and three sender idle profiles",
               vectors_sent);
      $display("%0d register writes, %0d results compared, %0d mismatches",
               register_writes, results_checked, mismatches);
      if (mismatches == 0) begin
         $display("point_rotate_translate_unit_tb OK");
      end else begin
         $display("point_rotate_translate_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
